// ===== rtl/mcm_pkg.sv =====
// Shared types and constants for the master clock generator with multipliers.
package mcm_pkg;

	localparam int unsigned KNOB_W       = 10;
	localparam int unsigned CURVE_W      = 10;
	localparam int unsigned SUB_PERIOD_W = 13;
	localparam int unsigned SHIFT_W      = 2;
	localparam int unsigned PHASE_W      = 4;
	localparam int unsigned STAMP_W      = 32;
	localparam int unsigned CHANNELS     = 3;

	localparam logic [KNOB_W-1:0]       FULL_SCALE  = 10'd1023;
	localparam logic [SUB_PERIOD_W-1:0] BASE_PERIOD = 13'd100;
	localparam logic [PHASE_W-1:0]      RISE_MASK   = 4'b1000;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_EDGE = 1'b1
	} mcm_action_t;

	// One sampled item with the knob and CV values already turned into
	// the curve entry and divider shifts that a boundary would load.
	typedef struct packed {
		mcm_action_t              action;
		logic [CURVE_W-1:0]       curve;
		logic [SHIFT_W-1:0]       shift1;
		logic [SHIFT_W-1:0]       shift2;
		logic [CHANNELS-1:0]      nudge;
		logic                     resync;
	} mcm_item_t;

endpackage

// ===== rtl/master_clock_with_multipliers_top.sv =====
// Top level of the three-output master clock generator with multipliers.
//
// Each input transfer is either a 100 us tick (action low) or a pin edge
// event (action high). A tick advances the time base; when a sub-period has
// passed it samples the rate and ratio knobs and CVs, reloads the sub-period
// from the cubic rate curve, reloads the two divider shifts and raises the
// gates whose phase counters say so and clears the lamps. Gates fall after
// eight sub-periods, divided by the channel's shift. An edge event nudges
// the nudged channels' phases and lights their lamps; a high resync clears
// all phases and lights all lamps. Every input transfer produces exactly one
// output transfer carrying the gate and lamp levels after that item.
// The sampling register, where the curve lookup is done, takes the item at
// the accepting edge and the state update then loads the result into the
// core registers, so both registers lie between the input transfer and the
// output transfer. One item is accepted every cycle while the receiver does
// not stall; throughput is set by the state update.
// Reset clears the channels, sets the sub-period to 100 ticks and drives
// all gates high. While the receiver stalls, the result holds and the
// sampling register can still take one more item before in_stall rises.
module master_clock_with_multipliers_top #(
	parameter int unsigned CURVE_DEPTH = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [mcm_pkg::KNOB_W-1:0] rate_knob,
	input  logic [mcm_pkg::KNOB_W-1:0] rate_cv,
	input  logic [mcm_pkg::KNOB_W-1:0] ratio1_knob,
	input  logic [mcm_pkg::KNOB_W-1:0] ratio1_cv,
	input  logic [mcm_pkg::KNOB_W-1:0] ratio2_knob,
	input  logic [mcm_pkg::KNOB_W-1:0] ratio2_cv,
	input  logic                       nudge0,
	input  logic                       nudge1,
	input  logic                       nudge2,
	input  logic                       resync,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       gate0,
	output logic                       gate1,
	output logic                       gate2,
	output logic                       lamp0,
	output logic                       lamp1,
	output logic                       lamp2
);
	import mcm_pkg::*;

	logic                advance;
	logic                item_valid;
	mcm_item_t           item;
	logic [CHANNELS-1:0] gates;
	logic [CHANNELS-1:0] lamps;

	// The sampling register precomputes everything a boundary would load.
	mcm_sample_stage #(
		.CURVE_DEPTH(CURVE_DEPTH)
	) u_sample (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (mcm_action_t'(action)),
		.rate_knob  (rate_knob),
		.rate_cv    (rate_cv),
		.ratio1_knob(ratio1_knob),
		.ratio1_cv  (ratio1_cv),
		.ratio2_knob(ratio2_knob),
		.ratio2_cv  (ratio2_cv),
		.nudge      ({nudge2, nudge1, nudge0}),
		.resync     (resync),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	// The core holds the time base and channel state; its state registers
	// double as the result register.
	mcm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gates     (gates),
		.lamps     (lamps)
	);

	assign gate0 = gates[0];
	assign gate1 = gates[1];
	assign gate2 = gates[2];
	assign lamp0 = lamps[0];
	assign lamp1 = lamps[1];
	assign lamp2 = lamps[2];

	// Back-pressure on the input only ever comes from a stalled result.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// A new result only appears when a sampled item was waiting.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(item_valid))
		else $error("result produced with no sampled item");

	// The gates and lamps change only when the core takes an item.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(item_valid && advance) |-> $stable({gates, lamps}))
		else $error("gate or lamp changed without an item");

endmodule

// ===== rtl/mcm_curve_rom.sv =====
// Cubic rate curve lookup that turns the rate knob and CV into a curve entry.
module mcm_curve_rom #(
	parameter int unsigned CURVE_DEPTH = 512
) (
	input  logic [mcm_pkg::KNOB_W-1:0]  rate_knob,
	input  logic [mcm_pkg::KNOB_W-1:0]  rate_cv,
	output logic [mcm_pkg::CURVE_W-1:0] curve
);
	import mcm_pkg::*;

	localparam int unsigned IdxW   = $clog2(CURVE_DEPTH);
	localparam int unsigned WideW  = $clog2(CURVE_DEPTH + 1);
	localparam int unsigned ProdW  = KNOB_W + WideW;
	localparam longint unsigned CurveDen =
		64'(CURVE_DEPTH - 1) * 64'(CURVE_DEPTH - 1) * 64'(CURVE_DEPTH - 1);

	logic [CURVE_W-1:0] curve_tbl [CURVE_DEPTH];

	for (genvar i = 0; i < CURVE_DEPTH; i++) begin : g_curve
		localparam longint unsigned Num = 64'(i) * 64'(i) * 64'(i) * 64'(FULL_SCALE);
		localparam logic [CURVE_W-1:0] Entry = CURVE_W'(Num / CurveDen);
		assign curve_tbl[i] = Entry;
	end

	logic [KNOB_W:0]      rate_sum;
	logic [KNOB_W-1:0]    rate;
	logic [ProdW-1:0]     rate_prod;
	logic [WideW-1:0]     idx_wide;
	logic [IdxW-1:0]      idx;

	always_comb begin
		// The knob is inverted: full scale minus the sample.
		rate_sum  = {1'b0, FULL_SCALE - rate_knob} + {1'b0, rate_cv};
		rate      = rate_sum[KNOB_W] ? FULL_SCALE : rate_sum[KNOB_W-1:0];
		rate_prod = ProdW'(rate) * ProdW'(CURVE_DEPTH);
		idx_wide  = rate_prod[ProdW-1:KNOB_W];
		if (idx_wide >= WideW'(CURVE_DEPTH)) begin
			idx = IdxW'(CURVE_DEPTH - 1);
		end else begin
			idx = idx_wide[IdxW-1:0];
		end
		// The entry goes straight into the sampling register, so the table
		// is read combinationally from the unregistered knob and CV inputs.
		curve = curve_tbl[idx];
	end

endmodule

// ===== rtl/mcm_sample_stage.sv =====
// Input register that samples one item and precomputes its boundary settings.
module mcm_sample_stage #(
	parameter int unsigned CURVE_DEPTH = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mcm_pkg::mcm_action_t         action,
	input  logic [mcm_pkg::KNOB_W-1:0]   rate_knob,
	input  logic [mcm_pkg::KNOB_W-1:0]   rate_cv,
	input  logic [mcm_pkg::KNOB_W-1:0]   ratio1_knob,
	input  logic [mcm_pkg::KNOB_W-1:0]   ratio1_cv,
	input  logic [mcm_pkg::KNOB_W-1:0]   ratio2_knob,
	input  logic [mcm_pkg::KNOB_W-1:0]   ratio2_cv,
	input  logic [mcm_pkg::CHANNELS-1:0] nudge,
	input  logic                         resync,
	input  logic                         advance,
	output logic                         item_valid,
	output mcm_pkg::mcm_item_t           item
);
	import mcm_pkg::*;

	logic [CURVE_W-1:0]      curve_new;
	logic [KNOB_W:0]         sum1;
	logic [KNOB_W:0]         sum2;
	logic [SHIFT_W-1:0]      shift1_new;
	logic [SHIFT_W-1:0]      shift2_new;
	logic                    accept;
	logic                    valid_s1;
	mcm_item_t               item_s1;

	mcm_curve_rom #(
		.CURVE_DEPTH(CURVE_DEPTH)
	) u_curve (
		.rate_knob(rate_knob),
		.rate_cv  (rate_cv),
		.curve    (curve_new)
	);

	always_comb begin
		sum1 = {1'b0, ratio1_knob} + {1'b0, ratio1_cv};
		sum2 = {1'b0, ratio2_knob} + {1'b0, ratio2_cv};
		// A clamped sum at full scale gives the top shift, as does any overflow.
		shift1_new = sum1[KNOB_W] ? FULL_SCALE[KNOB_W-1 -: SHIFT_W] : sum1[KNOB_W-1 -: SHIFT_W];
		shift2_new = sum2[KNOB_W] ? FULL_SCALE[KNOB_W-1 -: SHIFT_W] : sum2[KNOB_W-1 -: SHIFT_W];
		in_stall   = valid_s1 & ~advance;
		accept     = in_valid & ~in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action <= action;
			item_s1.curve  <= curve_new;
			item_s1.shift1 <= shift1_new;
			item_s1.shift2 <= shift2_new;
			item_s1.nudge  <= nudge;
			item_s1.resync <= resync;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ===== rtl/mcm_core.sv =====
// Gate generator state and result register, updated once per item.
module mcm_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  mcm_pkg::mcm_item_t           item,
	output logic                         advance,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mcm_pkg::CHANNELS-1:0] gates,
	output logic [mcm_pkg::CHANNELS-1:0] lamps
);
	import mcm_pkg::*;

	localparam int unsigned LimitW = SUB_PERIOD_W + 3;

	logic [STAMP_W-1:0]      tick_count_q;
	logic [STAMP_W-1:0]      last_boundary_q;
	logic [STAMP_W-1:0]      rise_stamp_q [CHANNELS];
	logic [CHANNELS-1:0]     gate_q;
	logic [CHANNELS-1:0]     lamp_q;
	logic [SUB_PERIOD_W-1:0] sub_period_q;
	logic [SHIFT_W-1:0]      ratio_shift_q [2];
	logic [PHASE_W-1:0]      phase_q [CHANNELS];
	logic [PHASE_W-1:0]      edge_count_q;
	logic                    out_valid_q;

	logic                    process;
	logic                    is_tick;
	logic                    bnd;
	logic [STAMP_W-1:0]      elapsed;
	logic [SUB_PERIOD_W-1:0] period_n;
	logic [SHIFT_W-1:0]      shift_n [CHANNELS];
	logic [PHASE_W-1:0]      phase_sum [CHANNELS];
	logic [LimitW-1:0]       limit [CHANNELS];
	logic [STAMP_W-1:0]      since_rise [CHANNELS];
	logic [CHANNELS-1:0]     rise;
	logic [CHANNELS-1:0]     fall;
	logic [CHANNELS-1:0]     gate_n;
	logic [CHANNELS-1:0]     lamp_n;
	logic [PHASE_W-1:0]      phase_n [CHANNELS];

	always_comb begin
		advance  = ~out_valid_q | ~out_stall;
		process  = item_valid & advance;
		is_tick  = (item.action == ACT_TICK);
		elapsed  = tick_count_q - last_boundary_q;
		bnd      = is_tick & (elapsed >= STAMP_W'(sub_period_q));
		// The sub-period is the base period plus four times the curve entry.
		period_n = bnd ? (BASE_PERIOD + {1'b0, item.curve, 2'b00}) : sub_period_q;
		shift_n[0] = '0;
		shift_n[1] = bnd ? item.shift1 : ratio_shift_q[0];
		shift_n[2] = bnd ? item.shift2 : ratio_shift_q[1];

		for (int k = 0; k < CHANNELS; k++) begin
			phase_sum[k]  = edge_count_q + phase_q[k];
			rise[k]       = bnd & ~gate_q[k] & (|(phase_sum[k] & (RISE_MASK >> shift_n[k])));
			limit[k]      = {period_n, 3'b000} >> shift_n[k];
			since_rise[k] = tick_count_q - rise_stamp_q[k];
			fall[k]       = is_tick & gate_q[k] & (since_rise[k] >= STAMP_W'(limit[k]));
			gate_n[k]     = rise[k] | (gate_q[k] & ~fall[k]);
		end

		// Edge events bump the phase of each nudged channel; resync then
		// clears every phase and lights every lamp.
		for (int k = 0; k < CHANNELS; k++) begin
			if (is_tick) begin
				phase_n[k] = phase_q[k];
				lamp_n[k]  = bnd ? 1'b0 : lamp_q[k];
			end else if (item.resync) begin
				phase_n[k] = '0;
				lamp_n[k]  = 1'b1;
			end else begin
				phase_n[k] = phase_q[k] + PHASE_W'(item.nudge[k]);
				lamp_n[k]  = lamp_q[k] | item.nudge[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q     <= '0;
			last_boundary_q  <= '0;
			gate_q           <= '1;
			lamp_q           <= '0;
			sub_period_q     <= BASE_PERIOD;
			ratio_shift_q[0] <= '0;
			ratio_shift_q[1] <= '0;
			edge_count_q     <= '0;
			out_valid_q      <= 1'b0;
			for (int k = 0; k < CHANNELS; k++) begin
				rise_stamp_q[k] <= '0;
				phase_q[k]      <= '0;
			end
		end else begin
			if (process) begin
				out_valid_q <= 1'b1;
				gate_q      <= gate_n;
				lamp_q      <= lamp_n;
				for (int k = 0; k < CHANNELS; k++) begin
					phase_q[k] <= phase_n[k];
					if (rise[k]) begin
						rise_stamp_q[k] <= tick_count_q;
					end
				end
				if (is_tick) begin
					tick_count_q <= tick_count_q + 1'b1;
				end
				if (bnd) begin
					last_boundary_q  <= tick_count_q;
					sub_period_q     <= period_n;
					ratio_shift_q[0] <= shift_n[1];
					ratio_shift_q[1] <= shift_n[2];
					edge_count_q     <= edge_count_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign gates     = gate_q;
	assign lamps     = lamp_q;

endmodule

// ===== sim/master_clock_with_multipliers_top_test.sv =====
// Self-checking testbench for the three-output master clock generator with multipliers.
module master_clock_with_multipliers_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mcm_pkg::*;

	localparam int unsigned CURVE_DEPTH = 512;

	// The run is stopped here whatever happens. The slowest correct run is well under a
	// tenth of this.
	localparam int unsigned RUN_LIMIT_NS = 20_000_000;

	// The receiver holds off for one long stretch. It starts well inside the random part
	// so that the sender keeps offering items and the block fills up behind the stall.
	localparam int unsigned HOLD_START = 400;
	localparam int unsigned HOLD_LEN   = 400;

	// Number of items in the random part.
	localparam int unsigned RANDOM_ITEMS = 1200;

	typedef struct packed {
		mcm_action_t        action;
		logic [KNOB_W-1:0]  rate_knob;
		logic [KNOB_W-1:0]  rate_cv;
		logic [KNOB_W-1:0]  ratio1_knob;
		logic [KNOB_W-1:0]  ratio1_cv;
		logic [KNOB_W-1:0]  ratio2_knob;
		logic [KNOB_W-1:0]  ratio2_cv;
		logic [2:0]         nudge;
		logic               resync;
	} pin_item_t;

	typedef struct packed {
		logic [2:0] gate;
		logic [2:0] lamp;
	} gate_levels_t;

	// One row of the directed table. Where typed is set, the levels are the expected
	// result as written; otherwise the predictor supplies it.
	typedef struct packed {
		pin_item_t    item;
		logic         typed;
		gate_levels_t levels;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               action = 1'b0;
	logic [KNOB_W-1:0]  rate_knob = '0;
	logic [KNOB_W-1:0]  rate_cv = '0;
	logic [KNOB_W-1:0]  ratio1_knob = '0;
	logic [KNOB_W-1:0]  ratio1_cv = '0;
	logic [KNOB_W-1:0]  ratio2_knob = '0;
	logic [KNOB_W-1:0]  ratio2_cv = '0;
	logic               nudge0 = 1'b0;
	logic               nudge1 = 1'b0;
	logic               nudge2 = 1'b0;
	logic               resync = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               gate0;
	logic               gate1;
	logic               gate2;
	logic               lamp0;
	logic               lamp1;
	logic               lamp2;

	master_clock_with_multipliers_top #(
		.CURVE_DEPTH(CURVE_DEPTH)
	) i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------------------
	// Gate predictor. It keeps its own copy of the time base, the channel state and the
	// cubic rate curve, and it is advanced once for every accepted input transfer.
	// ------------------------------------------------------------------------------------
	logic [CURVE_W-1:0]      curve [CURVE_DEPTH];
	logic [STAMP_W-1:0]      now_tick;
	logic [STAMP_W-1:0]      boundary_tick;
	logic [STAMP_W-1:0]      rose_at [3];
	logic [2:0]              gate_lvl;
	logic [2:0]              lamp_lvl;
	logic [SUB_PERIOD_W-1:0] period_ticks;
	logic [SHIFT_W-1:0]      div_shift [2];
	logic [PHASE_W-1:0]      phase [3];
	logic [PHASE_W-1:0]      beat;

	gate_levels_t pending_levels [$];
	int unsigned  mismatches = 0;

	function automatic int unsigned clamp_full(input int unsigned v);
		return (v > FULL_SCALE) ? int'(FULL_SCALE) : v;
	endfunction

	task automatic reset_gates();
		longint unsigned span;
		longint unsigned denom;
		span = CURVE_DEPTH - 1;
		denom = span * span * span;
		// The curve is worked out exactly in integers: entry i is i cubed, scaled to full
		// scale and divided by the cube of the last index.
		for (longint unsigned i = 0; i < CURVE_DEPTH; i++) begin
			curve[i] = (denom == 0) ? '0 : CURVE_W'((i * i * i * FULL_SCALE) / denom);
		end
		now_tick = '0;
		boundary_tick = '0;
		gate_lvl = 3'b111;
		lamp_lvl = 3'b000;
		period_ticks = BASE_PERIOD;
		beat = '0;
		for (int k = 0; k < 3; k++) begin
			rose_at[k] = '0;
			phase[k] = '0;
		end
		div_shift[0] = '0;
		div_shift[1] = '0;
	endtask

	// True when the next tick will land on a sub-period boundary and sample the knobs.
	function automatic logic boundary_due();
		return (now_tick - boundary_tick) >= STAMP_W'(period_ticks);
	endfunction

	task automatic advance_gates(input pin_item_t it, output gate_levels_t lv);
		int unsigned rate;
		int unsigned idx;
		int unsigned limit;
		logic [PHASE_W:0] beat_sum;
		logic [PHASE_W-1:0] mask;
		if (it.action == ACT_EDGE) begin
			// Edge events move no time on. Each nudge bumps its channel's phase and
			// lights its lamp; resync then clears every phase and lights all lamps.
			for (int k = 0; k < 3; k++) begin
				if (it.nudge[k]) begin
					phase[k] = phase[k] + 1'b1;
					lamp_lvl[k] = 1'b1;
				end
			end
			if (it.resync) begin
				for (int k = 0; k < 3; k++) begin
					phase[k] = '0;
				end
				lamp_lvl = 3'b111;
			end
		end else begin
			if (boundary_due()) begin
				boundary_tick = now_tick;
				rate = clamp_full(int'(FULL_SCALE) - int'(it.rate_knob) + int'(it.rate_cv));
				idx = (rate * CURVE_DEPTH) >> 10;
				if (idx > CURVE_DEPTH - 1) begin
					idx = CURVE_DEPTH - 1;
				end
				period_ticks = BASE_PERIOD + {curve[idx], 2'b00};
				div_shift[0] = SHIFT_W'(clamp_full(int'(it.ratio1_knob) + int'(it.ratio1_cv)) >> 8);
				div_shift[1] = SHIFT_W'(clamp_full(int'(it.ratio2_knob) + int'(it.ratio2_cv)) >> 8);
				lamp_lvl = 3'b000;
				for (int k = 0; k < 3; k++) begin
					mask = RISE_MASK;
					if (k > 0) begin
						mask = RISE_MASK >> div_shift[k-1];
					end
					beat_sum = {1'b0, beat} + {1'b0, phase[k]};
					if ((beat_sum[PHASE_W-1:0] & mask) != '0 && !gate_lvl[k]) begin
						gate_lvl[k] = 1'b1;
						rose_at[k] = now_tick;
					end
				end
				beat = beat + 1'b1;
			end
			// A gate that has just risen is tested as well; it cannot fall yet because
			// every fall threshold is at least one base period.
			for (int k = 0; k < 3; k++) begin
				limit = int'(period_ticks) << 3;
				if (k > 0) begin
					limit = limit >> div_shift[k-1];
				end
				if (gate_lvl[k] && (now_tick - rose_at[k]) >= limit) begin
					gate_lvl[k] = 1'b0;
				end
			end
			now_tick = now_tick + 1;
		end
		lv.gate = gate_lvl;
		lv.lamp = lamp_lvl;
	endtask

	// ------------------------------------------------------------------------------------
	// Sender. Items go out in bursts of random length, some of them long, separated by
	// random gaps, and a burst is sometimes sent with no gap at all before it.
	// ------------------------------------------------------------------------------------
	int unsigned burst_left = 0;

	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	// Offers one item and holds it until the transfer takes place, then advances the
	// predictor and records the levels that the block must return.
	task automatic offer(input pin_item_t it, input logic typed, input gate_levels_t typed_lv);
		gate_levels_t lv;
		pace();
		in_valid <= 1'b1;
		action <= it.action;
		rate_knob <= it.rate_knob;
		rate_cv <= it.rate_cv;
		ratio1_knob <= it.ratio1_knob;
		ratio1_cv <= it.ratio1_cv;
		ratio2_knob <= it.ratio2_knob;
		ratio2_cv <= it.ratio2_cv;
		nudge0 <= it.nudge[0];
		nudge1 <= it.nudge[1];
		nudge2 <= it.nudge[2];
		resync <= it.resync;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_gates(it, lv);
		pending_levels.push_back(typed ? typed_lv : lv);
	endtask

	function automatic stim_row_t row(input mcm_action_t act, input int rk, input int rc,
		input int a1k, input int a1c, input int a2k, input int a2c, input logic [2:0] ndg,
		input logic rsy, input logic typed, input logic [2:0] gates, input logic [2:0] lamps);
		stim_row_t r;
		r.item.action = act;
		r.item.rate_knob = KNOB_W'(rk);
		r.item.rate_cv = KNOB_W'(rc);
		r.item.ratio1_knob = KNOB_W'(a1k);
		r.item.ratio1_cv = KNOB_W'(a1c);
		r.item.ratio2_knob = KNOB_W'(a2k);
		r.item.ratio2_cv = KNOB_W'(a2c);
		r.item.nudge = ndg;
		r.item.resync = rsy;
		r.typed = typed;
		r.levels.gate = gates;
		r.levels.lamp = lamps;
		return r;
	endfunction

	// Random items are mostly ticks. When the next tick lands on a boundary, the knob
	// values that it carries decide the coming sub-period, so most boundaries pick the
	// fastest rate and only a handful a slow one; the ratio knobs go through their
	// extremes and random values. Between boundaries the knobs carry random values that
	// the block must ignore.
	int unsigned slow_left = 4;

	task automatic random_item(output pin_item_t it);
		int unsigned pick;
		it.action = ($urandom_range(0, 7) == 0) ? ACT_EDGE : ACT_TICK;
		it.rate_knob = KNOB_W'($urandom);
		it.rate_cv = KNOB_W'($urandom);
		it.ratio1_knob = KNOB_W'($urandom);
		it.ratio1_cv = KNOB_W'($urandom);
		it.ratio2_knob = KNOB_W'($urandom);
		it.ratio2_cv = KNOB_W'($urandom);
		it.nudge = 3'($urandom);
		it.resync = ($urandom_range(0, 5) == 0);
		if (it.action == ACT_TICK && boundary_due()) begin
			pick = $urandom_range(0, 9);
			if (pick == 0 && slow_left != 0) begin
				slow_left--;
				// Half of the slow picks take the slowest setting, where the rate clamps at
				// full scale and the last curve entry is used.
				if ($urandom_range(0, 1) == 0) begin
					it.rate_knob = '0;
				end
			end else begin
				it.rate_knob = KNOB_W'(FULL_SCALE - $urandom_range(0, 15));
				it.rate_cv = KNOB_W'($urandom_range(0, 15));
			end
			case ($urandom_range(0, 2))
				0: begin
					it.ratio1_knob = '0;
					it.ratio1_cv = '0;
				end
				1: begin
					it.ratio1_knob = FULL_SCALE;
					it.ratio1_cv = FULL_SCALE;
				end
				default: ;
			endcase
			case ($urandom_range(0, 2))
				0: begin
					it.ratio2_knob = FULL_SCALE;
					it.ratio2_cv = FULL_SCALE;
				end
				1: begin
					it.ratio2_knob = '0;
					it.ratio2_cv = '0;
				end
				default: ;
			endcase
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Stimulus. Reset, then the directed table, then random items, then the drain.
	// ------------------------------------------------------------------------------------
	stim_row_t directed_rows [25];

	initial begin
		pin_item_t    it;
		int unsigned  sent;
		reset_gates();

		// The first rows can be read off directly: gates come out of reset high and stay
		// high for eight base periods, and no boundary comes before tick one hundred, so
		// lamps only change on edge events. The knob values on ticks here are extremes,
		// and those on edge events must be ignored.
		directed_rows = '{
			row(ACT_TICK, 0, 0, 0, 0, 0, 0, 3'b000, 1'b0, 1'b1, 3'b111, 3'b000),
			row(ACT_TICK, 1023, 1023, 1023, 1023, 1023, 1023, 3'b000, 1'b0, 1'b1, 3'b111, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b001, 1'b0, 1'b1, 3'b111, 3'b001),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b010, 1'b0, 1'b1, 3'b111, 3'b011),
			row(ACT_EDGE, 1023, 1023, 1023, 1023, 1023, 1023, 3'b100, 1'b0, 1'b1, 3'b111, 3'b111),
			// Nudges together with resync: the phases step and are then cleared.
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b111, 1'b1, 1'b1, 3'b111, 3'b111),
			row(ACT_EDGE, 682, 341, 682, 341, 682, 341, 3'b000, 1'b1, 1'b1, 3'b111, 3'b111),
			row(ACT_EDGE, 341, 682, 341, 682, 341, 682, 3'b000, 1'b0, 1'b1, 3'b111, 3'b111),
			row(ACT_TICK, 1023, 0, 0, 1023, 1023, 0, 3'b111, 1'b1, 1'b1, 3'b111, 3'b111),
			// The edge events below carry the master phase all the way round and the other
			// two half way, so the master phase counter wraps.
			row(ACT_EDGE, 1, 2, 4, 8, 16, 32, 3'b001, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 64, 128, 256, 512, 0, 0, 3'b011, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b101, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b111, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b001, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b011, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b101, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b111, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b001, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b011, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b101, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b111, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b001, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b011, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b101, 1'b0, 1'b0, 3'b000, 3'b000),
			row(ACT_EDGE, 0, 0, 0, 0, 0, 0, 3'b111, 1'b0, 1'b0, 3'b000, 3'b000)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].levels);
		end

		// The random part sends a fixed number of items.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			random_item(it);
			offer(it, 1'b0, '0);
			sent++;
		end
		in_valid <= 1'b0;

		// Drain: every expected transfer must come back, after which the bench waits on to
		// catch any stray result.
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// ------------------------------------------------------------------------------------
	// Receiver. The stall pattern is drawn anew at regular intervals from none, heavy random,
	// light random and a fixed rhythm, and once holds off for a long stretch.
	// ------------------------------------------------------------------------------------
	int unsigned rx_cycle = 0;
	int unsigned rx_mode = 0;

	always @(posedge clk) begin
		if (rx_cycle % 40 == 0) begin
			rx_mode = $urandom_range(0, 3);
		end
		if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ((rx_cycle % 7) < 3);
			endcase
		end
		rx_cycle++;
	end

	// ------------------------------------------------------------------------------------
	// Checker. Each output transfer is compared field by field with the oldest expected
	// levels.
	// ------------------------------------------------------------------------------------
	gate_levels_t want;
	gate_levels_t got;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_levels.size() == 0) begin
				$error("output transfer with no item outstanding");
				mismatches++;
			end else begin
				want = pending_levels.pop_front();
				got.gate = {gate2, gate1, gate0};
				got.lamp = {lamp2, lamp1, lamp0};
				for (int k = 0; k < 3; k++) begin
					if (got.gate[k] !== want.gate[k]) begin
						$error("gate%0d: expected %0d, actual %0d", k, want.gate[k], got.gate[k]);
						mismatches++;
					end
					if (got.lamp[k] !== want.lamp[k]) begin
						$error("lamp%0d: expected %0d, actual %0d", k, want.lamp[k], got.lamp[k]);
						mismatches++;
					end
				end
			end
		end
	end

endmodule
